FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the branch resolver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER_CLK(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER_CLK(label, clk, rst_n, expr)

`endif

`endif

FILE: design/x86nb_pkg.sv
// ----------------------------------------------------------------------------
// x86nb_pkg
// Types and constants shared by the near branch resolver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package x86nb_pkg;

    typedef enum logic [3:0] {
        CMD_JCC      = 4'd0,
        CMD_JMP_REL  = 4'd1,
        CMD_JMP_ABS  = 4'd2,
        CMD_CALL_REL = 4'd3,
        CMD_CALL_ABS = 4'd4,
        CMD_RET_NEAR = 4'd5,
        CMD_JCXZ     = 4'd6,
        CMD_LOOP     = 4'd7,
        CMD_LOOPE    = 4'd8,
        CMD_LOOPNE   = 4'd9
    } t_cmd;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_ZF = 2;
    localparam int FLAG_SF = 3;
    localparam int FLAG_OF = 4;

    localparam logic [31:0] SLOT_BYTES = 32'd8;

    // Condition groups selected by the upper three bits of the Jcc nibble.
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        t_cmd        cmd;
        logic        met;
        logic        zf;
        logic        as64;
        logic        op16;
        logic [31:0] rel_lo;
        logic        rel_c;
        logic        disp_neg;
        logic [63:0] rip;
        logic [63:0] abs_t;
        logic [63:0] rcx;
        logic [31:0] cnt_lo;
        logic        cnt_borrow;
        logic        lo_zero;
        logic        newlo_zero;
        logic [31:0] sp_lo;
        logic        sp_c;
        logic        sp_hi_ones;
        logic [31:0] rsp_hi;
    } t_s1;

    typedef struct packed {
        logic        taken;
        logic        use_abs;
        logic        push;
        logic [63:0] rel;
        logic [63:0] abs_t;
        logic [63:0] rip;
        logic [63:0] next_count;
        logic [63:0] next_sp;
    } t_s2;

endpackage

`default_nettype wire

FILE: design/x86nb_cond.sv
// ----------------------------------------------------------------------------
// x86nb_cond
// Evaluates the sixteen Jcc conditions against the arithmetic flags.
// ----------------------------------------------------------------------------
`default_nettype none

module x86nb_cond
    import x86nb_pkg::*;
(
    input  wire logic [3:0] i_cond_code,
    input  wire logic [4:0] i_flags,
    output logic            o_met
);

    logic w_cf;
    logic w_pf;
    logic w_zf;
    logic w_sf;
    logic w_of;
    logic w_raw;

    assign w_cf = i_flags[FLAG_CF];
    assign w_pf = i_flags[FLAG_PF];
    assign w_zf = i_flags[FLAG_ZF];
    assign w_sf = i_flags[FLAG_SF];
    assign w_of = i_flags[FLAG_OF];

    always_comb begin
        case (i_cond_code[3:1])
            CC_O:    w_raw = w_of;
            CC_B:    w_raw = w_cf;
            CC_Z:    w_raw = w_zf;
            CC_BE:   w_raw = w_cf | w_zf;
            CC_S:    w_raw = w_sf;
            CC_P:    w_raw = w_pf;
            CC_L:    w_raw = w_sf ^ w_of;
            CC_LE:   w_raw = w_zf | (w_sf ^ w_of);
            default: w_raw = 1'b0;
        endcase
    end

    // The low bit of the nibble selects the negated form.
    assign o_met = i_cond_code[0] ? ~w_raw : w_raw;

endmodule

`default_nettype wire

FILE: design/x86_64_near_branch_resolver.sv
// ----------------------------------------------------------------------------
// x86_64_near_branch_resolver
// Three-stage pipelined resolver for 64-bit-mode near control transfers.
// ----------------------------------------------------------------------------
// The block accepts one item every clock cycle while o_stall is low, and
// each item passes the stage one, stage two and output registers. Stage one
// evaluates the condition and the low 32 bits of the target, counter and
// stack additions, stage two finishes the upper 32 bits and decides whether
// the branch is taken, and stage three selects the next RIP and holds the
// result in the output registers. Each stage advances whenever its successor
// is empty or moving, so a stall on the output only stops the stages that
// are full.
`default_nettype none

`include "assert_macros.svh"

module x86_64_near_branch_resolver
    import x86nb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_command,
    input  wire logic [3:0]         i_cond_code,
    input  wire logic signed [31:0] i_displacement,
    input  wire logic [63:0]        i_abs_target,
    input  wire logic [4:0]         i_flags,
    input  wire logic               i_addr_size_64,
    input  wire logic               i_op_size_16,
    input  wire logic [63:0]        i_current_rip,
    input  wire logic [63:0]        i_current_count,
    input  wire logic [63:0]        i_current_sp,
    input  wire logic [15:0]        i_stack_adjust,

    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [63:0]             o_next_rip,
    output logic [63:0]             o_next_count,
    output logic [63:0]             o_next_sp,
    output logic                    o_taken,
    output logic                    o_push_valid,
    output logic [63:0]             o_push_value
);

    logic        r_s1_vld;
    logic        r_s2_vld;
    logic        r_out_vld;
    t_s1         r_s1;
    t_s1         n_s1;
    t_s2         r_s2;
    t_s2         n_s2;
    logic [63:0] r_next_rip;
    logic [63:0] n_next_rip;
    logic [63:0] r_next_count;
    logic [63:0] r_next_sp;
    logic        r_taken;
    logic        r_push_valid;
    logic [63:0] r_push_value;
    logic [63:0] n_push_value;

    logic        w_rdy_out;
    logic        w_rdy_s2;
    logic        w_rdy_s1;
    logic        w_met;
    t_cmd        w_cmd;
    logic [32:0] w_rel_lo;
    logic [31:0] w_sp_op_lo;
    logic        w_sp_op_ones;
    logic [32:0] w_sp_lo;

    logic [31:0] w_rel_hi;
    logic [31:0] w_cnt_hi;
    logic [31:0] w_sp_hi;
    logic        w_hi_zero;
    logic        w_newhi_zero;
    logic        w_cnt_nz;
    logic        w_cx_zero;

    // Ready chain: a stage may load when it is empty or its item moves on.
    assign w_rdy_out = ~r_out_vld | ~i_stall;
    assign w_rdy_s2  = ~r_s2_vld | w_rdy_out;
    assign w_rdy_s1  = ~r_s1_vld | w_rdy_s2;
    assign o_stall   = ~w_rdy_s1;

    // Stage one: condition and low halves of the additions.
    x86nb_cond u_cond (
        .i_cond_code (i_cond_code),
        .i_flags     (i_flags),
        .o_met       (w_met)
    );

    assign w_cmd    = t_cmd'(i_command);
    assign w_rel_lo = {1'b0, i_current_rip[31:0]} + {1'b0, $unsigned(i_displacement)};

    always_comb begin
        case (w_cmd)
            CMD_CALL_REL, CMD_CALL_ABS: begin
                w_sp_op_lo   = 32'd0 - SLOT_BYTES;
                w_sp_op_ones = 1'b1;
            end
            CMD_RET_NEAR: begin
                w_sp_op_lo   = SLOT_BYTES + {16'd0, i_stack_adjust};
                w_sp_op_ones = 1'b0;
            end
            default: begin
                w_sp_op_lo   = 32'd0;
                w_sp_op_ones = 1'b0;
            end
        endcase
    end

    assign w_sp_lo = {1'b0, i_current_sp[31:0]} + {1'b0, w_sp_op_lo};

    always_comb begin
        n_s1.cmd        = w_cmd;
        n_s1.met        = w_met;
        n_s1.zf         = i_flags[FLAG_ZF];
        n_s1.as64       = i_addr_size_64;
        n_s1.op16       = i_op_size_16;
        n_s1.rel_lo     = w_rel_lo[31:0];
        n_s1.rel_c      = w_rel_lo[32];
        n_s1.disp_neg   = i_displacement[31];
        n_s1.rip        = i_current_rip;
        n_s1.abs_t      = i_abs_target;
        n_s1.rcx        = i_current_count;
        n_s1.cnt_lo     = i_current_count[31:0] - 32'd1;
        n_s1.cnt_borrow = (i_current_count[31:0] == 32'd0);
        n_s1.lo_zero    = (i_current_count[31:0] == 32'd0);
        n_s1.newlo_zero = (i_current_count[31:0] == 32'd1);
        n_s1.sp_lo      = w_sp_lo[31:0];
        n_s1.sp_c       = w_sp_lo[32];
        n_s1.sp_hi_ones = w_sp_op_ones;
        n_s1.rsp_hi     = i_current_sp[63:32];
    end

    // Stage two: upper halves, counter tests and the taken decision.
    assign w_rel_hi = r_s1.rip[63:32] + {32{r_s1.disp_neg}} + {31'd0, r_s1.rel_c};
    assign w_cnt_hi = r_s1.rcx[63:32] - {31'd0, r_s1.cnt_borrow};
    assign w_sp_hi  = r_s1.rsp_hi + {32{r_s1.sp_hi_ones}} + {31'd0, r_s1.sp_c};

    assign w_hi_zero    = (r_s1.rcx[63:32] == 32'd0);
    assign w_newhi_zero = (w_hi_zero & ~r_s1.cnt_borrow)
                        | ((r_s1.rcx[63:32] == 32'd1) & r_s1.cnt_borrow);
    assign w_cnt_nz     = r_s1.as64 ? ~(r_s1.newlo_zero & w_newhi_zero) : ~r_s1.newlo_zero;
    assign w_cx_zero    = r_s1.as64 ? (r_s1.lo_zero & w_hi_zero) : r_s1.lo_zero;

    always_comb begin
        n_s2.taken      = 1'b0;
        n_s2.use_abs    = 1'b0;
        n_s2.push       = 1'b0;
        n_s2.next_count = r_s1.rcx;
        case (r_s1.cmd)
            CMD_JCC:      n_s2.taken = r_s1.met;
            CMD_JMP_REL:  n_s2.taken = 1'b1;
            CMD_CALL_REL: begin
                n_s2.taken = 1'b1;
                n_s2.push  = 1'b1;
            end
            CMD_JMP_ABS, CMD_RET_NEAR: begin
                n_s2.taken   = 1'b1;
                n_s2.use_abs = 1'b1;
            end
            CMD_CALL_ABS: begin
                n_s2.taken   = 1'b1;
                n_s2.use_abs = 1'b1;
                n_s2.push    = 1'b1;
            end
            CMD_JCXZ:     n_s2.taken = w_cx_zero;
            CMD_LOOP, CMD_LOOPE, CMD_LOOPNE: begin
                n_s2.next_count = r_s1.as64 ? {w_cnt_hi, r_s1.cnt_lo}
                                            : {r_s1.rcx[63:32], r_s1.cnt_lo};
                if (r_s1.cmd == CMD_LOOPE) begin
                    n_s2.taken = w_cnt_nz & r_s1.zf;
                end else if (r_s1.cmd == CMD_LOOPNE) begin
                    n_s2.taken = w_cnt_nz & ~r_s1.zf;
                end else begin
                    n_s2.taken = w_cnt_nz;
                end
            end
            default: n_s2.taken = 1'b0;
        endcase
        n_s2.rel     = r_s1.op16 ? {48'd0, r_s1.rel_lo[15:0]} : {w_rel_hi, r_s1.rel_lo};
        n_s2.abs_t   = r_s1.abs_t;
        n_s2.rip     = r_s1.rip;
        n_s2.next_sp = {w_sp_hi, r_s1.sp_lo};
    end

    // Stage three: final target selection into the output registers.
    always_comb begin
        if (!r_s2.taken) begin
            n_next_rip = r_s2.rip;
        end else if (r_s2.use_abs) begin
            n_next_rip = r_s2.abs_t;
        end else begin
            n_next_rip = r_s2.rel;
        end
        n_push_value = r_s2.push ? r_s2.rip : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_rdy_s1) begin
                r_s1_vld <= i_valid;
            end
            if (w_rdy_s2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_rdy_out) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy_s2 && r_s1_vld) begin
            r_s2 <= n_s2;
        end
        if (w_rdy_out && r_s2_vld) begin
            r_next_rip   <= n_next_rip;
            r_next_count <= r_s2.next_count;
            r_next_sp    <= r_s2.next_sp;
            r_taken      <= r_s2.taken;
            r_push_valid <= r_s2.push;
            r_push_value <= n_push_value;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_next_rip   = r_next_rip;
    assign o_next_count = r_next_count;
    assign o_next_sp    = r_next_sp;
    assign o_taken      = r_taken;
    assign o_push_valid = r_push_valid;
    assign o_push_value = r_push_value;

    `ASSERT_CLK(a_push_is_taken, i_clk, i_rst_n, (o_valid && o_push_valid) |-> o_taken)
    `ASSERT_CLK(a_no_push_zero, i_clk, i_rst_n, (o_valid && !o_push_valid) |-> (o_push_value == 64'd0))
    `ASSERT_CLK(a_s2_held, i_clk, i_rst_n, (r_s2_vld && r_out_vld && i_stall) |=> r_s2_vld)
    `ASSERT_NEVER_CLK(a_stall_only_full, i_clk, i_rst_n, o_stall && !(r_s1_vld && r_s2_vld && r_out_vld))

endmodule

`default_nettype wire
